// ----- sv/tks_pkg.sv -----
// ----------------------------------------------------------------------------
// tks_pkg
// Shared constants and types of the streaming top-k score selector.
// ----------------------------------------------------------------------------
package tks_pkg;

  // Sizing of the kept list and the position counter.
  localparam int MAX_KEEP    = 8;
  localparam int INDEX_BITS  = 16;
  localparam int POS_W       = INDEX_BITS + 1;
  localparam int CNT_W       = $clog2(MAX_KEEP + 1);
  localparam int RANK_W      = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  // Fixed field widths of the ports.
  localparam int SCORE_W     = 32;
  localparam int IDX_OUT_W   = 16;
  localparam int RANK_OUT_W  = 3;
  localparam int KEEP_W      = 4;
  localparam int EXCL_W      = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  // Request queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_KEEP_COUNT     = 1'b0;
  localparam cfg_idx_t REG_EXCLUDED_INDEX = 1'b1;

  localparam logic [KEEP_W-1:0] KEEP_COUNT_RST = KEEP_W'(4);

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [INDEX_BITS-1:0]     idx;
    logic                      insert;
    logic                      last;
  } item_t;

  // One result as it leaves the back part.
  typedef struct packed {
    logic                      valid;
    logic [IDX_OUT_W-1:0]      index;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_OUT_W-1:0]     rank;
    logic                      empty_res;
    logic                      final_res;
  } result_t;

endpackage

// ----- sv/tks_front.sv -----
// ----------------------------------------------------------------------------
// tks_front
// Counts vector positions and classifies each accepted request as eligible
// for insertion or not.
// ----------------------------------------------------------------------------
module tks_front
  import tks_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic                      last_i,
  input  logic [EXCL_W-1:0]         excluded_index_i,
  output logic                      push_o,
  output item_t                     item_o
);

  localparam int CMP_W = (POS_W > EXCL_W) ? POS_W : EXCL_W;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(1) << INDEX_BITS;

  logic [POS_W-1:0] position_q, position_d;
  logic             in_range;
  logic             excluded;

  // A position is eligible when it is inside the index range and not excluded.
  assign in_range = (position_q < POS_LIMIT);
  assign excluded = (CMP_W'(position_q) == CMP_W'(excluded_index_i));

  assign push_o        = accept_i;
  assign item_o.score  = score_i;
  assign item_o.idx    = position_q[INDEX_BITS-1:0];
  assign item_o.insert = in_range && !excluded;
  assign item_o.last   = last_i;

  // The counter saturates past the range and restarts after the last element.
  always_comb begin
    position_d = position_q;
    if (accept_i) begin
      if (last_i) begin
        position_d = '0;
      end else if (in_range) begin
        position_d = position_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
    end else begin
      position_q <= position_d;
    end
  end

endmodule

// ----- sv/tks_queue.sv -----
// ----------------------------------------------------------------------------
// tks_queue
// Short request queue that decouples the classifying front from the
// insertion and emission back.
// ----------------------------------------------------------------------------
module tks_queue
  import tks_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  not_empty_o,
  output logic  full_o
);

  item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o      = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign pop_item_o  = slots_q[rd_ptr_q];

  // Storage of the queued requests.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ----- sv/tks_back.sv -----
// ----------------------------------------------------------------------------
// tks_back
// Row of compare-and-shift cells that keeps the best scores sorted, and the
// sequencer that shifts the row out as ranked results at the end of a vector.
// ----------------------------------------------------------------------------
module tks_back
  import tks_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  item_t             item_i,
  input  logic [KEEP_W-1:0] keep_count_i,
  output logic              pop_o,
  output result_t           result_o
);

  typedef enum logic {
    ST_RUN,
    ST_EMIT
  } state_e;

  state_e                    state_q;
  logic signed [SCORE_W-1:0] score_q [MAX_KEEP];
  logic [INDEX_BITS-1:0]     idx_q   [MAX_KEEP];
  logic [CNT_W-1:0]          kept_q;
  logic [CNT_W-1:0]          remain_q;
  logic [RANK_W-1:0]         rank_q;
  result_t                   result_q;

  logic [CNT_W-1:0]    k_eff;
  logic [CNT_W-1:0]    kc_eff;
  logic [MAX_KEEP-1:0] beats;
  logic [MAX_KEEP-1:0] take;
  logic [MAX_KEEP-1:0] take_prev;
  logic [CNT_W-1:0]    count_ins;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    count_emit;

  assign pop_o    = (state_q == ST_RUN) && item_valid_i;
  assign result_o = result_q;

  // Effective list length: zero acts as one, large values clamp to the row size.
  always_comb begin
    if (keep_count_i == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(keep_count_i) > MAX_KEEP) begin
      k_eff = CNT_W'(MAX_KEEP);
    end else begin
      k_eff = CNT_W'(keep_count_i);
    end
    kc_eff = (kept_q > k_eff) ? k_eff : kept_q;
  end

  // Each cell compares the new score against its own entry. A cell takes the
  // new entry where the run of winning cells starts and shifts from its
  // neighbor inside the run; the free cell after the list closes the run.
  // The list is cut to the current keep count only when an insertion is tried,
  // so a skipped element leaves the count as it was.
  always_comb begin
    for (int j = 0; j < MAX_KEEP; j++) begin
      beats[j] = (CNT_W'(j) < kc_eff) && (item_i.score > score_q[j]);
      take[j]  = (CNT_W'(j) < k_eff) && (beats[j] || (CNT_W'(j) == kc_eff));
    end
    take_prev = {take[MAX_KEEP-2:0], 1'b0};
    count_ins = (kc_eff < k_eff) ? (kc_eff + CNT_W'(1)) : k_eff;
    if (item_i.insert) begin
      count_next = (|take) ? count_ins : kc_eff;
    end else begin
      count_next = kept_q;
    end
    count_emit = (count_next > k_eff) ? k_eff : count_next;
  end

  // Cell row: insertion on a popped request, shift toward the head on emission.
  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.insert) begin
      for (int j = 0; j < MAX_KEEP; j++) begin
        if (take[j] && !take_prev[j]) begin
          score_q[j] <= item_i.score;
          idx_q[j]   <= item_i.idx;
        end else if (take[j] && (j > 0)) begin
          score_q[j] <= score_q[(j > 0) ? j - 1 : 0];
          idx_q[j]   <= idx_q[(j > 0) ? j - 1 : 0];
        end
      end
    end else if (state_q == ST_EMIT) begin
      for (int j = 0; j < MAX_KEEP - 1; j++) begin
        score_q[j] <= score_q[j + 1];
        idx_q[j]   <= idx_q[j + 1];
      end
    end
  end

  // Sequencer with the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_RUN;
      kept_q   <= '0;
      remain_q <= '0;
      rank_q   <= '0;
      result_q <= '0;
    end else begin
      unique case (state_q)
        ST_RUN: begin
          result_q.valid <= pop_o && item_i.last && (count_emit == '0);
          if (pop_o) begin
            if (item_i.last) begin
              kept_q <= '0;
              if (count_emit == '0) begin
                // Nothing eligible: one flagged result closes the run.
                result_q.index     <= '0;
                result_q.score     <= '0;
                result_q.rank      <= '0;
                result_q.empty_res <= 1'b1;
                result_q.final_res <= 1'b1;
              end else begin
                state_q  <= ST_EMIT;
                remain_q <= count_emit;
                rank_q   <= '0;
              end
            end else begin
              kept_q <= count_next;
            end
          end
        end
        ST_EMIT: begin
          // The head cell is the best remaining entry.
          result_q.valid     <= 1'b1;
          result_q.index     <= IDX_OUT_W'(idx_q[0]);
          result_q.score     <= score_q[0];
          result_q.rank      <= RANK_OUT_W'(rank_q);
          result_q.empty_res <= 1'b0;
          result_q.final_res <= (remain_q == CNT_W'(1));
          remain_q           <= remain_q - CNT_W'(1);
          rank_q             <= rank_q + RANK_W'(1);
          if (remain_q == CNT_W'(1)) begin
            state_q <= ST_RUN;
          end
        end
      endcase
    end
  end

endmodule

// ----- sv/top_k_score_selector.sv -----
// ----------------------------------------------------------------------------
// top_k_score_selector
// Streaming top-k selection: keeps the best scores of a vector sorted and
// emits them best first, as index, score and rank, after the last element.
// ----------------------------------------------------------------------------
// A request is written into the queue at acceptance and enters the cell row
// when the back pops it; a vector's first result is registered from the head
// cell in the emission state after the last element's entry, or at that entry
// when nothing was kept. One element per cycle is taken while the queue has
// room; the last element holds the row while the kept entries are emitted,
// and the four-deep queue absorbs new elements. Results cannot be stalled.
// Reset clears position, kept list and queue; keep_count=4, excluded_index=0.
// ----------------------------------------------------------------------------
module top_k_score_selector
  import tks_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [SCORE_W-1:0]    score_i,
  input  logic                         last_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic                         result_valid_o,
  output logic [IDX_OUT_W-1:0]         index_o,
  output logic signed [SCORE_W-1:0]    picked_score_o,
  output logic [RANK_OUT_W-1:0]        rank_o,
  output logic                         empty_res_o,
  output logic                         final_res_o
);

  logic [KEEP_W-1:0] keep_count_q;
  logic [EXCL_W-1:0] excluded_index_q;

  logic    accept;
  logic    push;
  item_t   push_item;
  item_t   pop_item;
  logic    pop;
  logic    queue_not_empty;
  logic    queue_full;
  result_t result;

  // A request is taken whenever the queue has room.
  assign busy   = queue_full;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q     <= KEEP_COUNT_RST;
      excluded_index_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEEP_COUNT:     keep_count_q     <= cfg_wdata_i[KEEP_W-1:0];
        REG_EXCLUDED_INDEX: excluded_index_q <= cfg_wdata_i[EXCL_W-1:0];
      endcase
    end
  end

  tks_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .score_i          (score_i),
    .last_i           (last_i),
    .excluded_index_i (excluded_index_q),
    .push_o           (push),
    .item_o           (push_item)
  );

  tks_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .not_empty_o (queue_not_empty),
    .full_o      (queue_full)
  );

  tks_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (queue_not_empty),
    .item_i       (pop_item),
    .keep_count_i (keep_count_q),
    .pop_o        (pop),
    .result_o     (result)
  );

  assign result_valid_o = result.valid;
  assign index_o        = result.index;
  assign picked_score_o = result.score;
  assign rank_o         = result.rank;
  assign empty_res_o    = result.empty_res;
  assign final_res_o    = result.final_res;

  // A ranked result other than the best follows a non-final result directly.
  a_rank_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (rank_o != '0) |-> $past(result_valid_o) && !$past(final_res_o))
    else $error("ranked result without a preceding result of the same run");

  // The empty result is alone in its run.
  a_empty_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && empty_res_o |-> final_res_o && (rank_o == '0))
    else $error("empty result is not the single final result");

  // Emission of a run has no gaps.
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !final_res_o |=> result_valid_o)
    else $error("gap inside the emission of a run");

endmodule

// ----- sim/tks_checker.sv -----
// ----------------------------------------------------------------------------
// tks_checker
// Watches the request, configuration and result ports of the top-k score
// selector. It keeps its own copy of the registers and of the kept list,
// works out the picks that each vector must produce, and compares every
// result strobe field by field with the oldest pick still waiting.
// ----------------------------------------------------------------------------
module tks_checker
  import tks_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  input  logic                      busy,
  input  logic signed [SCORE_W-1:0] score_i,
  input  logic                      last_i,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                      result_valid_o,
  input  logic [IDX_OUT_W-1:0]      index_o,
  input  logic signed [SCORE_W-1:0] picked_score_o,
  input  logic [RANK_OUT_W-1:0]     rank_o,
  input  logic                      empty_res_o,
  input  logic                      final_res_o,
  output int                        fail_cnt_o,
  output int                        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // One pick as the selector must report it.
  typedef struct {
    logic [IDX_OUT_W-1:0]      index;
    logic signed [SCORE_W-1:0] score;
    logic [RANK_OUT_W-1:0]     rank;
    logic                      empty_res;
    logic                      final_res;
  } pick_t;

  pick_t pick_q[$];

  // Register copies and the shadow kept list.
  logic [KEEP_W-1:0]         keep_reg;
  logic [EXCL_W-1:0]         excl_reg;
  logic [POS_W-1:0]          next_pos;
  int unsigned               kept_n;
  logic signed [SCORE_W-1:0] best_score [MAX_KEEP];
  logic [INDEX_BITS-1:0]     best_idx [MAX_KEEP];

  initial begin
    fail_cnt_o = 0;
    pending_o  = 0;
  end

  task automatic flag_mismatch(input string what);
    $display("%0t ns  tks_checker: %s", $time, what);
    fail_cnt_o++;
  endtask

  // Zero keeps one entry, and anything above the list depth keeps all of it.
  function automatic int unsigned keep_limit();
    int unsigned k;
    k = int'(keep_reg);
    if (k < 1) k = 1;
    if (k > MAX_KEEP) k = MAX_KEEP;
    return k;
  endfunction

  // Fold one element into the kept list and queue the picks on the last one.
  task automatic absorb_element(input logic signed [SCORE_W-1:0] s, input logic is_last);
    int unsigned k;
    int unsigned p;
    int unsigned j;
    int unsigned n;
    pick_t       pk;
    k = keep_limit();
    if (next_pos[INDEX_BITS] == 1'b0) begin
      if (next_pos != {1'b0, excl_reg}) begin
        // A lowered keep count cuts the list before the insertion.
        if (kept_n > k) kept_n = k;
        p = 0;
        while (p < kept_n && !(s > best_score[p])) p++;
        if (p < k) begin
          j = (kept_n < k) ? kept_n : k - 1;
          while (j > p) begin
            best_score[j] = best_score[j-1];
            best_idx[j]   = best_idx[j-1];
            j--;
          end
          best_score[p] = s;
          best_idx[p]   = next_pos[INDEX_BITS-1:0];
          if (kept_n < k) kept_n++;
        end
      end
      next_pos++;
    end
    if (is_last) begin
      n = (kept_n > k) ? k : kept_n;
      if (n == 0) begin
        pk.index     = '0;
        pk.score     = '0;
        pk.rank      = '0;
        pk.empty_res = 1'b1;
        pk.final_res = 1'b1;
        pick_q = {pick_q, pk};
      end else begin
        for (int unsigned r = 0; r < n; r++) begin
          pk.index     = IDX_OUT_W'(best_idx[r]);
          pk.score     = best_score[r];
          pk.rank      = RANK_OUT_W'(r);
          pk.empty_res = 1'b0;
          pk.final_res = (r + 1 == n);
          pick_q = {pick_q, pk};
        end
      end
      next_pos = '0;
      kept_n   = 0;
    end
  endtask

  // Compare one result strobe with the oldest waiting pick.
  task automatic check_pick();
    pick_t want;
    if (pick_q.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected: index %0d score %0d",
                              index_o, picked_score_o));
      return;
    end
    want = pick_q.pop_front();
    if (index_o !== want.index)
      flag_mismatch($sformatf("rank %0d: index %0d, want %0d", want.rank, index_o, want.index));
    if (picked_score_o !== want.score)
      flag_mismatch($sformatf("rank %0d: score %0d, want %0d", want.rank, picked_score_o,
                              want.score));
    if (rank_o !== want.rank)
      flag_mismatch($sformatf("rank %0d, want %0d", rank_o, want.rank));
    if (empty_res_o !== want.empty_res)
      flag_mismatch($sformatf("rank %0d: empty flag %b, want %b", want.rank, empty_res_o,
                              want.empty_res));
    if (final_res_o !== want.final_res)
      flag_mismatch($sformatf("rank %0d: final flag %b, want %b", want.rank, final_res_o,
                              want.final_res));
  endtask

  // Everything is sampled at the rising edge, where inputs are stable.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_reg = KEEP_COUNT_RST;
      excl_reg = '0;
      next_pos = '0;
      kept_n   = 0;
      pick_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_KEEP_COUNT) keep_reg = cfg_wdata_i[KEEP_W-1:0];
        else if (cfg_idx_i == REG_EXCLUDED_INDEX) excl_reg = cfg_wdata_i[EXCL_W-1:0];
      end
      if (result_valid_o === 1'b1) check_pick();
      else if (result_valid_o !== 1'b0) flag_mismatch("result strobe is unknown");
      if (start && busy === 1'b0) absorb_element(score_i, last_i);
    end
    pending_o = pick_q.size();
  end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the top-k score selector: a directed part over the register
// extremes, ties, the excluded position and a mid-vector keep count change,
// then random vectors in bursts under random register settings. The checker
// beside the block predicts and compares; this module only drives and gives
// the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam int RAND_ITEMS = 200;
  localparam int DRAIN_CYC  = 24;

  logic                      clk_i;
  logic                      rst_ni      = 1'b0;
  logic                      start       = 1'b0;
  logic signed [SCORE_W-1:0] score_i     = '0;
  logic                      last_i      = 1'b0;
  logic                      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i   = REG_KEEP_COUNT;
  logic [CFG_DATA_W-1:0]     cfg_wdata_i = '0;
  logic                      busy;
  logic                      result_valid_o;
  logic [IDX_OUT_W-1:0]      index_o;
  logic signed [SCORE_W-1:0] picked_score_o;
  logic [RANK_OUT_W-1:0]     rank_o;
  logic                      empty_res_o;
  logic                      final_res_o;
  int                        fail_cnt;
  int                        pending;

  int                        burst_left = 0;
  int                        items_sent = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  top_k_score_selector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .score_i        (score_i),
    .last_i         (last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .index_o        (index_o),
    .picked_score_o (picked_score_o),
    .rank_o         (rank_o),
    .empty_res_o    (empty_res_o),
    .final_res_o    (final_res_o)
  );

  tks_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .score_i        (score_i),
    .last_i         (last_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .index_o        (index_o),
    .picked_score_o (picked_score_o),
    .rank_o         (rank_o),
    .empty_res_o    (empty_res_o),
    .final_res_o    (final_res_o),
    .fail_cnt_o     (fail_cnt),
    .pending_o      (pending)
  );

  // Send one element request; it is called and returns at a falling edge.
  // The requests come in bursts with random gaps.
  task automatic push_elem(input logic signed [SCORE_W-1:0] s, input logic is_last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    start   <= 1'b1;
    score_i <= s;
    last_i  <= is_last;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Stop sending and wait until every pick has come and the queue is empty.
  task automatic settle();
    start <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Extremes and a narrow band that makes ties common.
  function automatic logic signed [SCORE_W-1:0] pick_score();
    case ($urandom_range(0, 9))
      0:       return SCORE_MIN;
      1:       return SCORE_MAX;
      2, 3:    return SCORE_W'($urandom_range(0, 8)) - SCORE_W'(4);
      default: return $urandom;
    endcase
  endfunction

  // Random register setting; the keep count write sometimes carries junk above
  // its four bits, and the excluded position is mostly one that short vectors hit.
  task automatic random_setting();
    logic [CFG_DATA_W-1:0] kdata;
    logic [CFG_DATA_W-1:0] xdata;
    if ($urandom_range(0, 3) != 0) begin
      if ($urandom_range(0, 3) == 0) kdata = CFG_DATA_W'($urandom);
      else kdata = CFG_DATA_W'($urandom_range(1, MAX_KEEP));
      write_reg(REG_KEEP_COUNT, kdata);
    end
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 3) == 0) xdata = CFG_DATA_W'($urandom);
      else xdata = CFG_DATA_W'($urandom_range(0, 10));
      write_reg(REG_EXCLUDED_INDEX, xdata);
    end
  endtask

  initial begin
    int n;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting: the only element sits at the excluded position.
    push_elem(32'sd5, 1'b1);
    settle();

    // Both extremes, a tie at the top and a dropped minimum, keep count four.
    push_elem(32'sh12345678, 1'b0);
    push_elem(SCORE_MIN, 1'b0);
    push_elem(SCORE_MAX, 1'b0);
    push_elem(SCORE_MAX, 1'b0);
    push_elem(-32'sd1, 1'b0);
    push_elem(32'sd0, 1'b1);
    settle();

    // Keep count zero acts as one; equal scores go to the lowest position.
    write_reg(REG_KEEP_COUNT, 16'hFFF0);
    write_reg(REG_EXCLUDED_INDEX, 16'd3);
    push_elem(32'sd1, 1'b0);
    push_elem(32'sd1, 1'b0);
    push_elem(32'sd1, 1'b0);
    push_elem(32'sd9, 1'b0);
    push_elem(32'sd1, 1'b1);
    settle();

    // Keep count above the list depth keeps eight.
    write_reg(REG_KEEP_COUNT, 16'h000F);
    write_reg(REG_EXCLUDED_INDEX, 16'hFFFF);
    push_elem(-32'sd5, 1'b0);
    push_elem(32'sd7, 1'b0);
    push_elem(32'sd7, 1'b0);
    push_elem(32'sd100, 1'b0);
    push_elem(-32'sd100, 1'b0);
    push_elem(32'sd3, 1'b0);
    push_elem(32'sd50, 1'b0);
    push_elem(32'sd2, 1'b0);
    push_elem(32'sd8, 1'b0);
    push_elem(32'sd1, 1'b1);
    settle();

    // Keep count lowered while a vector is half way in.
    write_reg(REG_KEEP_COUNT, 16'd8);
    push_elem(32'sd4, 1'b0);
    push_elem(32'sd3, 1'b0);
    push_elem(32'sd2, 1'b0);
    push_elem(32'sd1, 1'b0);
    settle();
    write_reg(REG_KEEP_COUNT, 16'd2);
    push_elem(32'sd5, 1'b0);
    push_elem(32'sd0, 1'b1);
    settle();

    // Random vectors; phases end anywhere, so a setting often changes mid-vector.
    items_sent = 0;
    while (items_sent < RAND_ITEMS) begin
      random_setting();
      n = $urandom_range(8, 40);
      repeat (n) push_elem(pick_score(), $urandom_range(0, 5) == 0);
      settle();
    end
    push_elem(pick_score(), 1'b1);
    settle();

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- top_k_score_selector.f -----
sv/tks_pkg.sv
sv/tks_front.sv
sv/tks_queue.sv
sv/tks_back.sv
sv/top_k_score_selector.sv
sim/tks_checker.sv
sim/tb_top.sv
